@@ design/three_phase_sine_pwm_compare_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the three-phase sine compare block
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef THREE_PHASE_SINE_PWM_COMPARE_DEFINES_SVH
`define THREE_PHASE_SINE_PWM_COMPARE_DEFINES_SVH

// same-cycle implication
`define TSPWM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TSPWM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/tspwm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspwm_pkg
// Shared types and constants of the three-phase sine compare block.
// ----------------------------------------------------------------------------
package tspwm_pkg;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ANGLE,
		ST_MULP,
		ST_IDX,
		ST_LOOK,
		ST_SCALE,
		ST_DONE
	} state_t;

	// configuration register indexes
	localparam logic [2:0] REG_PERIOD = 3'd0;
	localparam logic [2:0] REG_STEPS  = 3'd1;
	localparam logic [2:0] REG_INC    = 3'd2;
	localparam logic [2:0] REG_MOD    = 3'd3;
	localparam logic [2:0] REG_START  = 3'd4;

	// register reset values
	localparam logic [15:0] RST_PERIOD = 16'd1071;
	localparam logic [15:0] RST_STEPS  = 16'd1400;
	localparam logic [15:0] RST_INC    = 16'd47;
	localparam logic [15:0] RST_MOD    = 16'd32768;
	localparam logic [15:0] RST_START  = 16'd0;

	// phase offsets in 2^-16 turn
	localparam logic [15:0] THIRD_TURN      = 16'd21845;
	localparam logic [15:0] TWO_THIRDS_TURN = 16'd43691;

	// phase selector codes
	localparam logic [1:0] PH_A = 2'd0;
	localparam logic [1:0] PH_B = 2'd1;
	localparam logic [1:0] PH_C = 2'd2;

	// sine table generation constants, Q30
	localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;

endpackage

@@ design/tspwm_sine_rom.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspwm_sine_rom
// Full-wave Q15 sine table, built at elaboration, registered read.
// ----------------------------------------------------------------------------
module tspwm_sine_rom #(
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic [$clog2(DEPTH)-1:0] addr,
	output logic signed [15:0]       data
);

	typedef logic signed [15:0] rom_t [DEPTH];

	// Taylor series to x^13 in Horner form, quarter-wave folded
	function automatic rom_t build_rom();
		rom_t        tbl;
		logic [63:0] u;
		logic [63:0] q;
		logic [63:0] r;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		for (int k = 0; k < DEPTH; k++) begin
			u = 64'(k) * 64'd4;
			q = u / DEPTH;
			r = u % DEPTH;
			if (q[0]) begin
				r = 64'(DEPTH) - r;
			end
			x  = (tspwm_pkg::PI_HALF_Q30 * r) / DEPTH;
			x2 = (x * x) >> 30;
			t  = tspwm_pkg::ONE_Q30;
			t  = tspwm_pkg::ONE_Q30 - ((x2 * t) >> 30) / 156;
			t  = tspwm_pkg::ONE_Q30 - ((x2 * t) >> 30) / 110;
			t  = tspwm_pkg::ONE_Q30 - ((x2 * t) >> 30) / 72;
			t  = tspwm_pkg::ONE_Q30 - ((x2 * t) >> 30) / 42;
			t  = tspwm_pkg::ONE_Q30 - ((x2 * t) >> 30) / 20;
			t  = tspwm_pkg::ONE_Q30 - ((x2 * t) >> 30) / 6;
			s  = (x * t) >> 30;
			s  = (s + 64'd16384) >> 15;
			if (s > 64'd32767) begin
				s = 64'd32767;
			end
			tbl[k] = (q >= 64'd2) ? -16'(s) : 16'(s);
		end
		return tbl;
	endfunction

	localparam rom_t SINE_ROM = build_rom();

	logic signed [15:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= SINE_ROM[addr];
	end

	assign data = data_q;

endmodule

@@ design/three_phase_sine_pwm_compare.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_phase_sine_pwm_compare
// Three-phase sinusoidal compare generator, one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / tick): one transfer per carrier
//   period. A transfer with tick low is taken but yields nothing.
//   Output channel (out_valid / out_stall): one result per tick with the
//   three compare values and the step index used.
//   Config: cfg_we / cfg_index / cfg_data write one register per cycle; the user
//   must write only while no tick is in flight, the block does not enforce it. Indexes above 4 are ignored.
// Timing:
//   A tick runs through the sequencer states: angle, m*P, then index,
//   table read and scale for each of the three phases, all on one 32x16
//   multiplier with a registered product. The result is loaded into the
//   output register as the sequencer leaves DONE; a new tick is taken only
//   back in IDLE, after the last tick's result has been loaded.
// Reset:
//   Step counter to 0, registers to their defaults, output empty.
// Stall:
//   The result waits in the output register; a finished tick whose result
//   finds that register still full waits in its last state.
// ----------------------------------------------------------------------------
module three_phase_sine_pwm_compare #(
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        tick,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] compare_a,
	output logic [15:0] compare_b,
	output logic [15:0] compare_c,
	output logic [15:0] step_index
);

`include "three_phase_sine_pwm_compare_defines.svh"

	localparam int          IW      = $clog2(SINE_TABLE_DEPTH);
	localparam logic [15:0] DEPTH_W = 16'(SINE_TABLE_DEPTH);

	tspwm_pkg::state_t state_q, state_d;

	logic [15:0] period_q, steps_q, inc_q, mod_q, start_q;
	logic [15:0] step_cnt_q;
	logic [1:0]  phase_q;
	logic [15:0] angle_q;
	logic [31:0] mp_q;
	logic [47:0] prod_q;
	logic [15:0] cmp_q [3];

	logic        out_valid_q;
	logic [15:0] out_a_q, out_b_q, out_c_q, out_idx_q;

	logic [31:0]        mul_a;
	logic [15:0]        mul_b;
	logic [1:0]         phase_sel;
	logic [15:0]        phase_ofs;
	logic [15:0]        angle_p;
	logic signed [15:0] sine;
	logic [14:0]        duty;
	logic signed [19:0] diff;
	logic [15:0]        cmp_sat;
	logic [16:0]        cnt_inc;
	logic [15:0]        cnt_next;
	logic               in_fire;
	logic               done_fire;

	assign in_fire = in_valid && !in_stall;

	// ---- sine table ----
	tspwm_sine_rom #(
		.DEPTH(SINE_TABLE_DEPTH)
	) u_rom (
		.clk  (clk),
		.addr (prod_q[16 +: IW]),
		.data (sine)
	);

	// ---- next state ----
	always_comb begin
		state_d = state_q;
		case (state_q)
			tspwm_pkg::ST_IDLE:  if (in_fire && tick) state_d = tspwm_pkg::ST_ANGLE;
			tspwm_pkg::ST_ANGLE: state_d = tspwm_pkg::ST_MULP;
			tspwm_pkg::ST_MULP:  state_d = tspwm_pkg::ST_IDX;
			tspwm_pkg::ST_IDX:   state_d = tspwm_pkg::ST_LOOK;
			tspwm_pkg::ST_LOOK:  state_d = tspwm_pkg::ST_SCALE;
			tspwm_pkg::ST_SCALE: begin
				if (phase_q == tspwm_pkg::PH_C) state_d = tspwm_pkg::ST_DONE;
				else                            state_d = tspwm_pkg::ST_IDX;
			end
			tspwm_pkg::ST_DONE:  if (done_fire) state_d = tspwm_pkg::ST_IDLE;
			default:             state_d = tspwm_pkg::ST_IDLE;
		endcase
	end

	// ---- sequencer outputs: multiplier operand select ----
	always_comb begin
		in_stall  = (state_q != tspwm_pkg::ST_IDLE);
		done_fire = (state_q == tspwm_pkg::ST_DONE) && (!out_valid_q || !out_stall);
		// in SCALE the next phase's index product is issued
		phase_sel = (state_q == tspwm_pkg::ST_SCALE) ? phase_q + 2'd1 : phase_q;
		case (phase_sel)
			tspwm_pkg::PH_B: phase_ofs = tspwm_pkg::THIRD_TURN;
			tspwm_pkg::PH_C: phase_ofs = tspwm_pkg::TWO_THIRDS_TURN;
			default:         phase_ofs = 16'd0;
		endcase
		angle_p = angle_q + phase_ofs;
		case (state_q)
			tspwm_pkg::ST_IDLE: begin
				mul_a = {16'd0, step_cnt_q};
				mul_b = inc_q;
			end
			tspwm_pkg::ST_ANGLE: begin
				mul_a = {16'd0, mod_q};
				mul_b = period_q;
			end
			tspwm_pkg::ST_MULP, tspwm_pkg::ST_SCALE: begin
				mul_a = {16'd0, angle_p};
				mul_b = DEPTH_W;
			end
			tspwm_pkg::ST_LOOK: begin
				mul_a = mp_q;
				mul_b = {1'b0, duty};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// (sine + 32768) >> 1: adding 2^15 flips the sign bit
	assign duty = {~sine[15], sine[14:1]};

	// c = P - 1 - (m*P*d >> 30) with d = (sine + 32768) >> 1, floored at zero
	assign diff    = signed'({4'd0, period_q}) - 20'sd1 - signed'({2'd0, prod_q[47:30]});
	assign cmp_sat = diff[19] ? 16'd0 : diff[15:0];

	assign cnt_inc  = {1'b0, step_cnt_q} + 17'd1;
	assign cnt_next = (cnt_inc >= {1'b0, steps_q}) ? 16'd0 : cnt_inc[15:0];

	// ---- shared multiplier and datapath ----
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		case (state_q)
			tspwm_pkg::ST_ANGLE: angle_q <= prod_q[15:0] + start_q;
			tspwm_pkg::ST_MULP:  mp_q <= prod_q[31:0];
			tspwm_pkg::ST_SCALE: cmp_q[phase_q] <= cmp_sat;
			default: ;
		endcase
		if (done_fire) begin
			out_a_q   <= cmp_q[tspwm_pkg::PH_A];
			out_b_q   <= cmp_q[tspwm_pkg::PH_B];
			out_c_q   <= cmp_q[tspwm_pkg::PH_C];
			out_idx_q <= step_cnt_q;
		end
	end

	// ---- control registers ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tspwm_pkg::ST_IDLE;
			phase_q     <= tspwm_pkg::PH_A;
			step_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			period_q    <= tspwm_pkg::RST_PERIOD;
			steps_q     <= tspwm_pkg::RST_STEPS;
			inc_q       <= tspwm_pkg::RST_INC;
			mod_q       <= tspwm_pkg::RST_MOD;
			start_q     <= tspwm_pkg::RST_START;
		end else begin
			state_q <= state_d;
			if (state_q == tspwm_pkg::ST_ANGLE) begin
				phase_q <= tspwm_pkg::PH_A;
			end else if (state_q == tspwm_pkg::ST_SCALE) begin
				phase_q <= phase_q + 2'd1;
			end
			if (done_fire) begin
				step_cnt_q  <= cnt_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					tspwm_pkg::REG_PERIOD: period_q <= cfg_data;
					tspwm_pkg::REG_STEPS:  steps_q  <= cfg_data;
					tspwm_pkg::REG_INC:    inc_q    <= cfg_data;
					tspwm_pkg::REG_MOD:    mod_q    <= cfg_data;
					tspwm_pkg::REG_START:  start_q  <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign compare_a  = out_a_q;
	assign compare_b  = out_b_q;
	assign compare_c  = out_c_q;
	assign step_index = out_idx_q;

	// ---- assertions ----
	`TSPWM_ASSERT_NXT(a_tick_starts, in_fire && tick, state_q == tspwm_pkg::ST_ANGLE, "tick transfer did not start the sequencer")
	`TSPWM_ASSERT_NXT(a_done_loads, done_fire, out_valid && state_q == tspwm_pkg::ST_IDLE, "finished tick did not load the output")
	`TSPWM_ASSERT_NXT(a_last_phase, state_q == tspwm_pkg::ST_SCALE && phase_q == tspwm_pkg::PH_C, state_q == tspwm_pkg::ST_DONE, "sequencer ran past phase C")
	`TSPWM_ASSERT_NXT(a_cnt_wrap, done_fire && !cfg_we, step_cnt_q == 16'd0 || step_cnt_q < steps_q, "step counter beyond cycle length")

endmodule
